FILE: hdl/ocd_pkg.sv
package ocd_pkg;

    // Panel geometry
    localparam int PAGES      = 8;
    localparam int COLUMNS    = 132;
    localparam int RAM_DEPTH  = PAGES * COLUMNS;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int PAGE_W     = 3;

    // Item kinds (tuser)
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Command byte codes
    localparam logic [7:0] C_COL_LO_FIRST = 8'h00;
    localparam logic [7:0] C_COL_LO_LAST  = 8'h0F;
    localparam logic [7:0] C_COL_HI_FIRST = 8'h10;
    localparam logic [7:0] C_COL_HI_LAST  = 8'h1F;
    localparam logic [7:0] C_LINE_FIRST   = 8'h40;
    localparam logic [7:0] C_LINE_LAST    = 8'h7F;
    localparam logic [7:0] C_PAGE_FIRST   = 8'hB0;
    localparam logic [7:0] C_PAGE_LAST    = 8'hBF;
    localparam logic [7:0] C_CONTRAST     = 8'h81;
    localparam logic [7:0] C_SEG_NORMAL   = 8'hA0;
    localparam logic [7:0] C_SEG_REMAP    = 8'hA1;
    localparam logic [7:0] C_ALL_ON_OFF   = 8'hA4;
    localparam logic [7:0] C_ALL_ON       = 8'hA5;
    localparam logic [7:0] C_INV_OFF      = 8'hA6;
    localparam logic [7:0] C_INV_ON       = 8'hA7;
    localparam logic [7:0] C_DISP_OFF     = 8'hAE;
    localparam logic [7:0] C_DISP_ON      = 8'hAF;
    localparam logic [7:0] C_RMW_ENTER    = 8'hE0;
    localparam logic [7:0] C_RMW_LEAVE    = 8'hEE;

    localparam logic [7:0] CONTRAST_RESET = 8'd128;

    // Result item, last member in the lowest bits
    typedef struct packed {
        logic              rmw_mode;
        logic [5:0]        start_line;
        logic              seg_remap;
        logic              all_on;
        logic              inverted;
        logic              display_on;
        logic [7:0]        contrast;
        logic [7:0]        column;
        logic [PAGE_W-1:0] page;
        logic [7:0]        read_data;
    } t_result;

    localparam int RES_W  = $bits(t_result);
    localparam int RES_TW = ((RES_W + 7) / 8) * 8;

endpackage

FILE: hdl/oled_controller_command_decoder.sv
// Command decoder and display RAM of a page-organized monochrome OLED
// controller. Each input transfer carries one host byte: tuser says whether it
// is a command byte, a display-data write or a display-data read, and tdata
// carries the byte. Every input transfer yields exactly one output transfer
// that carries the read byte (zero unless a read) and the controller state
// after the item: page, column, contrast, the display mode flags, the start
// line and the read-modify-write flag. Commands and data writes are taken
// while the output slot is free or frees; with the output side ready they
// stream at one item per clock. A data read waits in S_READ for the
// registered read port of the frame RAM (PAGES x COLUMNS bytes); the next
// item is taken once the read byte sits in the output register. The output
// register frees a slot in the same cycle its transfer completes. Frame RAM
// has no reset: read only locations that were written. Columns at or beyond
// COLUMNS store nothing and read as zero; the column counter wraps at 256.
module oled_controller_command_decoder
    import ocd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] value
    input  logic [7:0]        s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [7:0] read_data, [10:8] page, [18:11] column, [26:19] contrast,
    // [27] display_on, [28] inverted, [29] all_on, [30] seg_remap,
    // [36:31] start_line, [37] rmw_mode, [39:38] zero
    output logic [RES_TW-1:0] m_axis_tdata
);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state            r_state;
    t_result           r_out;
    logic              r_out_valid;
    logic              r_rd_hit;

    logic [PAGE_W-1:0] r_page,      n_page;
    logic [7:0]        r_column,    n_column;
    logic [7:0]        r_rmw_col,   n_rmw_col;
    logic [7:0]        r_contrast,  n_contrast;
    logic              r_pending,   n_pending;
    logic              r_disp_on,   n_disp_on;
    logic              r_inverted,  n_inverted;
    logic              r_all_on,    n_all_on;
    logic              r_seg_remap, n_seg_remap;
    logic              r_rmw,       n_rmw;
    logic [5:0]        r_start,     n_start;

    logic              w_accept;
    logic              w_in_range;
    logic [RAM_AW-1:0] w_addr;
    logic              w_we;
    logic              w_re;
    logic [7:0]        w_rdata;
    logic [1:0]        w_kind;
    logic [7:0]        w_val;
    t_result           w_res_now;

    assign w_kind = s_axis_tuser;
    assign w_val  = s_axis_tdata;

    // Output slot is free, or frees this cycle
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_in_range = (32'(r_column) < COLUMNS);
    assign w_addr     = RAM_AW'(32'(r_page) * COLUMNS + 32'(r_column));
    assign w_we       = w_accept && (w_kind == KIND_WRITE) && w_in_range;
    assign w_re       = w_accept && (w_kind == KIND_READ) && w_in_range;

    ocd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_val),
        .o_rdata (w_rdata)
    );

    // Next controller state for the offered item
    always_comb begin
        n_page      = r_page;
        n_column    = r_column;
        n_rmw_col   = r_rmw_col;
        n_contrast  = r_contrast;
        n_pending   = r_pending;
        n_disp_on   = r_disp_on;
        n_inverted  = r_inverted;
        n_all_on    = r_all_on;
        n_seg_remap = r_seg_remap;
        n_rmw       = r_rmw;
        n_start     = r_start;
        case (w_kind)
            KIND_CMD: begin
                if (r_pending) begin
                    // byte after 81 is the contrast value, whatever its code
                    n_contrast = w_val;
                    n_pending  = 1'b0;
                end else if (w_val inside {[C_COL_LO_FIRST:C_COL_LO_LAST]}) begin
                    n_column = {r_column[7:4], w_val[3:0]};
                end else if (w_val inside {[C_COL_HI_FIRST:C_COL_HI_LAST]}) begin
                    n_column = {w_val[3:0], r_column[3:0]};
                end else if (w_val inside {[C_LINE_FIRST:C_LINE_LAST]}) begin
                    n_start = w_val[5:0];
                end else if (w_val inside {[C_PAGE_FIRST:C_PAGE_LAST]}) begin
                    if (32'(w_val[3:0]) < PAGES) begin
                        n_page = w_val[PAGE_W-1:0];
                    end
                end else begin
                    case (w_val)
                        C_CONTRAST:   n_pending   = 1'b1;
                        C_SEG_NORMAL: n_seg_remap = 1'b0;
                        C_SEG_REMAP:  n_seg_remap = 1'b1;
                        C_ALL_ON_OFF: n_all_on    = 1'b0;
                        C_ALL_ON:     n_all_on    = 1'b1;
                        C_INV_OFF:    n_inverted  = 1'b0;
                        C_INV_ON:     n_inverted  = 1'b1;
                        C_DISP_OFF:   n_disp_on   = 1'b0;
                        C_DISP_ON:    n_disp_on   = 1'b1;
                        C_RMW_ENTER: begin
                            n_rmw     = 1'b1;
                            n_rmw_col = r_column;
                        end
                        C_RMW_LEAVE: begin
                            if (r_rmw) begin
                                n_column = r_rmw_col;
                                n_rmw    = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            KIND_WRITE: n_column = r_column + 8'd1;
            KIND_READ: begin
                if (!r_rmw) begin
                    n_column = r_column + 8'd1;
                end
            end
            default: ;
        endcase
    end

    // Result of a non-read item, taken from the next state
    always_comb begin
        w_res_now            = '0;
        w_res_now.page       = n_page;
        w_res_now.column     = n_column;
        w_res_now.contrast   = n_contrast;
        w_res_now.display_on = n_disp_on;
        w_res_now.inverted   = n_inverted;
        w_res_now.all_on     = n_all_on;
        w_res_now.seg_remap  = n_seg_remap;
        w_res_now.start_line = n_start;
        w_res_now.rmw_mode   = n_rmw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_page      <= '0;
            r_column    <= '0;
            r_rmw_col   <= '0;
            r_contrast  <= CONTRAST_RESET;
            r_pending   <= 1'b0;
            r_disp_on   <= 1'b0;
            r_inverted  <= 1'b0;
            r_all_on    <= 1'b0;
            r_seg_remap <= 1'b0;
            r_rmw       <= 1'b0;
            r_start     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_page      <= n_page;
                        r_column    <= n_column;
                        r_rmw_col   <= n_rmw_col;
                        r_contrast  <= n_contrast;
                        r_pending   <= n_pending;
                        r_disp_on   <= n_disp_on;
                        r_inverted  <= n_inverted;
                        r_all_on    <= n_all_on;
                        r_seg_remap <= n_seg_remap;
                        r_rmw       <= n_rmw;
                        r_start     <= n_start;
                        if (w_kind == KIND_READ) begin
                            // slot was empty or drains on this edge
                            r_rd_hit    <= w_in_range;
                            r_out_valid <= 1'b0;
                            r_state     <= S_READ;
                        end else begin
                            r_out       <= w_res_now;
                            r_out_valid <= 1'b1;
                        end
                    end else if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    // state registers already hold the post-item values
                    r_out.read_data  <= r_rd_hit ? w_rdata : 8'd0;
                    r_out.page       <= r_page;
                    r_out.column     <= r_column;
                    r_out.contrast   <= r_contrast;
                    r_out.display_on <= r_disp_on;
                    r_out.inverted   <= r_inverted;
                    r_out.all_on     <= r_all_on;
                    r_out.seg_remap  <= r_seg_remap;
                    r_out.start_line <= r_start;
                    r_out.rmw_mode   <= r_rmw;
                    r_out_valid      <= 1'b1;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = RES_TW'(r_out);

`ifndef SYNTHESIS
    // read data lands in an empty output slot
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("output slot busy while a read is in flight");

    a_read_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_kind == KIND_READ)) |=> (r_state == S_READ))
        else $error("read item did not wait for RAM data");

    a_read_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("read result not presented after RAM latency");

    a_column_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_column))
        else $error("column moved without an input transfer");
`endif

endmodule

FILE: hdl/ocd_ram.sv
module ocd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb.sv
module tb;
    import ocd_pkg::*;

    // cmd code 3 has no meaning in the controller; the block must ignore it
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int         RANDOM_BYTES = 500;

    // One host byte waiting to go out, with the status it must produce.
    // hold: wait until every result in flight has come back before offering it.
    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        bit         hold;
        t_result    status;
    } t_host_byte;

    // A run of data writes, kept so that later reads land on written bytes
    typedef struct {
        int pg;
        int col;
        int len;
    } t_span;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] value
    logic [1:0]        s_axis_tuser = '0;   // [1:0] cmd
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [RES_TW-1:0] m_axis_tdata;        // t_result, read_data in the lowest bits

    oled_controller_command_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Panel shadow: controller state as the byte stream leaves it
    // ------------------------------------------------------------------
    logic [7:0]        frame_mem [RAM_DEPTH];
    bit                frame_written [RAM_DEPTH];
    logic [PAGE_W-1:0] pm_page = '0;
    logic [7:0]        pm_col = '0;
    logic [7:0]        pm_rmw_col = '0;
    logic [7:0]        pm_contrast = CONTRAST_RESET;
    bit                pm_contrast_wait = 1'b0;
    bit                pm_disp_on = 1'b0;
    bit                pm_inv = 1'b0;
    bit                pm_all_on = 1'b0;
    bit                pm_remap = 1'b0;
    logic [5:0]        pm_line = '0;
    bit                pm_rmw = 1'b0;

    t_host_byte host_bytes [$];     // bytes still to be sent
    t_result    status_due [$];     // status words owed by the block, oldest first
    t_span      spans [$];
    bit         hold_next = 1'b1;   // first queued byte always waits for a drain

    int n_total = 0;
    int n_sent = 0;                 // updated with NBAs so both sides see edge-start values
    int n_recv = 0;
    int n_fail = 0;
    int n_far_reads = 0;
    int n_holds = 0;
    int kind_seen [4] = '{0, 0, 0, 0};

    // Apply one host byte to the shadow and return the status after it
    function automatic void advance_panel(input logic [1:0] kind, input logic [7:0] v,
                                          output t_result st);
        int         addr;
        logic [7:0] rd;
        addr = int'(pm_page) * COLUMNS + int'(pm_col);
        rd = '0;
        case (kind)
            KIND_CMD: begin
                // byte after 81 is the contrast value, whatever its code
                if (pm_contrast_wait) begin
                    pm_contrast = v;
                    pm_contrast_wait = 1'b0;
                end else if (v <= C_COL_LO_LAST) begin
                    pm_col[3:0] = v[3:0];
                end else if (v <= C_COL_HI_LAST) begin
                    pm_col[7:4] = v[3:0];
                end else if (v >= C_LINE_FIRST && v <= C_LINE_LAST) begin
                    pm_line = v[5:0];
                end else if (v >= C_PAGE_FIRST && v <= C_PAGE_LAST) begin
                    if (int'(v[3:0]) < PAGES) pm_page = v[PAGE_W-1:0];
                end else begin
                    case (v)
                        C_CONTRAST:   pm_contrast_wait = 1'b1;
                        C_SEG_NORMAL: pm_remap = 1'b0;
                        C_SEG_REMAP:  pm_remap = 1'b1;
                        C_ALL_ON_OFF: pm_all_on = 1'b0;
                        C_ALL_ON:     pm_all_on = 1'b1;
                        C_INV_OFF:    pm_inv = 1'b0;
                        C_INV_ON:     pm_inv = 1'b1;
                        C_DISP_OFF:   pm_disp_on = 1'b0;
                        C_DISP_ON:    pm_disp_on = 1'b1;
                        C_RMW_ENTER: begin
                            // re-entry just moves the restore point
                            pm_rmw = 1'b1;
                            pm_rmw_col = pm_col;
                        end
                        C_RMW_LEAVE: begin
                            if (pm_rmw) begin
                                pm_col = pm_rmw_col;
                                pm_rmw = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            KIND_WRITE: begin
                if (int'(pm_col) < COLUMNS) begin
                    frame_mem[addr] = v;
                    frame_written[addr] = 1'b1;
                end
                pm_col = pm_col + 8'd1;
            end
            KIND_READ: begin
                if (int'(pm_col) < COLUMNS) rd = frame_mem[addr];
                else n_far_reads++;
                if (!pm_rmw) pm_col = pm_col + 8'd1;
            end
            default: ;
        endcase
        st.read_data  = rd;
        st.page       = pm_page;
        st.column     = pm_col;
        st.contrast   = pm_contrast;
        st.display_on = pm_disp_on;
        st.inverted   = pm_inv;
        st.all_on     = pm_all_on;
        st.seg_remap  = pm_remap;
        st.start_line = pm_line;
        st.rmw_mode   = pm_rmw;
    endfunction

    function automatic void queue_byte(input logic [1:0] kind, input logic [7:0] v);
        t_host_byte hb;
        hb.kind  = kind;
        hb.value = v;
        hb.hold  = hold_next;
        advance_panel(kind, v, hb.status);
        hold_next = 1'b0;
        host_bytes.push_back(hb);
    endfunction

    // Reads only where the byte was written, or past the last column
    function automatic bit queue_read();
        if (int'(pm_col) >= COLUMNS ||
            frame_written[int'(pm_page) * COLUMNS + int'(pm_col)]) begin
            queue_byte(KIND_READ, 8'($urandom_range(0, 255)));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void seek_to(input int pg, input int col);
        queue_byte(KIND_CMD, C_PAGE_FIRST | 8'(pg % 16));
        queue_byte(KIND_CMD, C_COL_LO_FIRST | 8'(col % 16));
        queue_byte(KIND_CMD, C_COL_HI_FIRST | 8'((col / 16) % 16));
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed bytes, then random command sequences
    // ------------------------------------------------------------------
    initial begin
        int         pick;
        int         r;
        int         pg;
        int         col;
        int         len;
        int         k;
        int         n_directed;
        t_span      sp;
        logic [7:0] code;
        logic [7:0] mode_codes [9];

        mode_codes = '{C_SEG_NORMAL, C_SEG_REMAP, C_ALL_ON_OFF, C_ALL_ON, C_INV_OFF,
                       C_INV_ON, C_DISP_OFF, C_DISP_ON, C_LINE_FIRST};

        // leave read-modify-write while not in it: no effect on the reset state
        queue_byte(KIND_CMD, C_RMW_LEAVE);
        queue_byte(KIND_CMD, C_SEG_REMAP);
        queue_byte(KIND_CMD, C_ALL_ON);
        queue_byte(KIND_CMD, C_INV_ON);
        queue_byte(KIND_CMD, C_DISP_ON);
        queue_byte(KIND_CMD, C_LINE_LAST);
        // contrast extremes; a data byte between 81 and its value keeps it pending
        queue_byte(KIND_CMD, C_CONTRAST);
        queue_byte(KIND_CMD, 8'hFF);
        queue_byte(KIND_CMD, C_CONTRAST);
        queue_byte(KIND_WRITE, 8'h00);
        queue_byte(KIND_CMD, 8'h00);
        // last page, then a page beyond the panel that must be ignored
        queue_byte(KIND_CMD, C_PAGE_FIRST | 8'(PAGES - 1));
        queue_byte(KIND_CMD, C_PAGE_LAST);
        // column 0x8F is past the panel: write drops, read gives zero
        queue_byte(KIND_CMD, C_COL_LO_LAST);
        queue_byte(KIND_CMD, C_COL_HI_FIRST | 8'h08);
        queue_byte(KIND_WRITE, 8'hFF);
        void'(queue_read());
        queue_byte(KIND_CMD, C_COL_LO_FIRST);
        queue_byte(KIND_CMD, C_COL_HI_FIRST);
        queue_byte(KIND_WRITE, 8'h5A);
        // read-modify-write, re-entered once so the restore point moves
        queue_byte(KIND_CMD, C_COL_LO_FIRST);
        queue_byte(KIND_CMD, C_RMW_ENTER);
        void'(queue_read());
        queue_byte(KIND_WRITE, 8'hA5);
        queue_byte(KIND_CMD, C_RMW_ENTER);
        queue_byte(KIND_WRITE, 8'h3C);
        queue_byte(KIND_CMD, C_RMW_LEAVE);
        void'(queue_read());
        queue_byte(KIND_SPARE, 8'hFF);
        n_directed = host_bytes.size();

        while (host_bytes.size() < n_directed + RANDOM_BYTES) begin
            if ($urandom_range(0, 29) == 0) hold_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // data write run, sometimes off the panel or across the 255 wrap
                r = $urandom_range(0, 9);
                pg = (r == 0) ? $urandom_range(PAGES, 15) : $urandom_range(0, PAGES - 1);
                r = $urandom_range(0, 9);
                col = (r == 0) ? $urandom_range(120, 140) :
                      (r == 1) ? $urandom_range(240, 255) : $urandom_range(0, COLUMNS - 1);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 8);
                seek_to(pg, col);
                sp = '{int'(pm_page), int'(pm_col), len};
                spans.push_back(sp);
                if (spans.size() > 16) void'(spans.pop_front());
                repeat (len) queue_byte(KIND_WRITE, 8'($urandom_range(0, 255)));
            end else if (pick < 45 && spans.size() != 0) begin
                // read back an earlier run
                sp = spans[$urandom_range(0, spans.size() - 1)];
                seek_to(sp.pg, sp.col);
                k = 0;
                while (k < sp.len && queue_read()) k++;
            end else if (pick < 60) begin
                // read-modify-write over a run or anywhere
                if (spans.size() != 0 && $urandom_range(0, 9) < 7) begin
                    sp = spans[$urandom_range(0, spans.size() - 1)];
                    seek_to(sp.pg, sp.col);
                end else begin
                    seek_to($urandom_range(0, PAGES - 1), $urandom_range(0, 255));
                end
                queue_byte(KIND_CMD, C_RMW_ENTER);
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 6) == 0) queue_byte(KIND_CMD, C_RMW_ENTER);
                    void'(queue_read());
                    queue_byte(KIND_WRITE, 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 4) != 0) queue_byte(KIND_CMD, C_RMW_LEAVE);
            end else if (pick < 70) begin
                // contrast, with data bytes slipped in between now and then
                queue_byte(KIND_CMD, C_CONTRAST);
                repeat ($urandom_range(0, 2)) begin
                    if ($urandom_range(0, 1) == 0) void'(queue_read());
                    else queue_byte(KIND_WRITE, 8'($urandom_range(0, 255)));
                end
                r = $urandom_range(0, 9);
                code = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                queue_byte(KIND_CMD, code);
            end else if (pick < 85) begin
                // display mode flags and start line
                repeat ($urandom_range(1, 3)) begin
                    code = mode_codes[$urandom_range(0, 8)];
                    if (code == C_LINE_FIRST) code = code | 8'($urandom_range(0, 63));
                    queue_byte(KIND_CMD, code);
                end
            end else begin
                // noise: any command byte, stray data, unused code
                repeat ($urandom_range(1, 4)) begin
                    r = $urandom_range(0, 3);
                    if (r == int'(KIND_READ)) void'(queue_read());
                    else queue_byte(2'(r), 8'($urandom_range(0, 255)));
                end
            end
        end
        n_total = host_bytes.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_recv >= n_total);
        // extra cycles catch any stray result
        repeat (20) @(posedge i_clk);
        $display("Covered %0d command bytes, %0d data writes, %0d data reads (%0d off panel)",
                 kind_seen[KIND_CMD], kind_seen[KIND_WRITE], kind_seen[KIND_READ],
                 n_far_reads);
        $display("and %0d unused-code bytes; %0d drain pauses, %0d status words checked.",
                 kind_seen[KIND_SPARE], n_holds, n_recv);
        if (n_fail == 0 && status_due.size() == 0) begin
            $display("** oled_controller_command_decoder: PASSED **");
        end else begin
            $display("** oled_controller_command_decoder: FAILED **");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;
    bit fire;
    bit offer;
    bit drained;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire) begin
                // the block owes one status word per accepted byte
                status_due.push_back(host_bytes[0].status);
                kind_seen[host_bytes[0].kind]++;
                void'(host_bytes.pop_front());
                n_sent <= n_sent + 1;
            end
            // a new byte is chosen only when none is on offer
            if (!s_axis_tvalid || fire) begin
                offer = 1'b0;
                drained = (n_sent + int'(fire)) == n_recv;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (host_bytes.size() != 0 && (!host_bytes[0].hold || drained)) begin
                    offer = 1'b1;
                    if (host_bytes[0].hold) n_holds++;
                    s_axis_tdata <= host_bytes[0].value;
                    s_axis_tuser <= host_bytes[0].kind;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 7) == 0) begin
                            // long stretch with no idle cycles
                            burst_left = $urandom_range(40, 80);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 16);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                        end
                    end
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each status word, drives a stall pattern on tready
    // ------------------------------------------------------------------
    int      stall_mode = 0;
    int      mode_left = 64;
    int      stall_left = 0;
    bit      next_ready;
    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_recv <= n_recv + 1;
                got = t_result'(m_axis_tdata[RES_W-1:0]);
                if (status_due.size() == 0) begin
                    $error("status word 0x%0h with no byte waiting for it", m_axis_tdata);
                    n_fail++;
                end else begin
                    want = status_due.pop_front();
                    check_field("read_data",  want.read_data,      got.read_data);
                    check_field("page",       8'(want.page),       8'(got.page));
                    check_field("column",     want.column,         got.column);
                    check_field("contrast",   want.contrast,       got.contrast);
                    check_field("display_on", 8'(want.display_on), 8'(got.display_on));
                    check_field("inverted",   8'(want.inverted),   8'(got.inverted));
                    check_field("all_on",     8'(want.all_on),     8'(got.all_on));
                    check_field("seg_remap",  8'(want.seg_remap),  8'(got.seg_remap));
                    check_field("start_line", 8'(want.start_line), 8'(got.start_line));
                    check_field("rmw_mode",   8'(want.rmw_mode),   8'(got.rmw_mode));
                end
            end
            // modes: always ready, random 60 percent, or ready with stall bursts
            mode_left--;
            if (mode_left <= 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 200);
            end
            case (stall_mode)
                0: next_ready = 1'b1;
                1: next_ready = $urandom_range(0, 9) < 6;
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        next_ready = 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(3, 12);
                        next_ready = 1'b0;
                    end else begin
                        next_ready = 1'b1;
                    end
                end
            endcase
            m_axis_tready <= next_ready;
        end
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #400000;
        $display("** oled_controller_command_decoder: FAILED **");
        $finish;
    end

endmodule

FILE: oled_controller_command_decoder.f
hdl/ocd_pkg.sv
hdl/ocd_ram.sv
hdl/oled_controller_command_decoder.sv
tb/tb.sv
